// ----- rtl/core/c3wf_pkg.sv -----
// Package for the clamped 3x3 window fetch unit: sizes, constants and beat types.
`timescale 1ns / 1ps
`default_nettype none

package c3wf_pkg;

  // Store geometry: the row stride is always the maximum width
  localparam int unsigned MaxWidth   = 64;
  localparam int unsigned MaxHeight  = 64;
  localparam int unsigned CoordW     = 6;
  localparam int unsigned SizeW      = 7;
  localparam int unsigned PixW       = 8;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned WinSize    = 9;
  localparam int unsigned WinIdxW    = $clog2(WinSize);

  // Operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  // Configuration register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [PixW-1:0]   pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [CoordW-1:0] centre_x;
    logic [CoordW-1:0] centre_y;
    logic [PixW-1:0]   nw;
    logic [PixW-1:0]   n;
    logic [PixW-1:0]   ne;
    logic [PixW-1:0]   w;
    logic [PixW-1:0]   c;
    logic [PixW-1:0]   e;
    logic [PixW-1:0]   sw;
    logic [PixW-1:0]   s;
    logic [PixW-1:0]   se;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/clamped_3x3_window_fetch_unit.sv -----
// Top level of the clamped 3x3 window fetch unit: image store, fetch sequencer, output register.
// Write beat: the pixel lands in the single-port image store at the accept edge.
// Read beat: the fetch state makes nine store reads (one per cycle on the single read/write
//   port), the flush state stores the last read data, then hold loads the output register.
// Sustained rate: 1 beat per cycle for writes while idle; a read takes no new beat until its
//   window is loaded for output; a stalled output holds the next beat off until it drains.
// Reset: width and height return to 64, control and handshakes clear; the store keeps
//   whatever it holds and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module clamped_3x3_window_fetch_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [c3wf_pkg::SizeW-1:0]   cfg_data_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire c3wf_pkg::in_beat_t           in_data_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output c3wf_pkg::out_beat_t               out_data_o
);

  localparam int unsigned CW = c3wf_pkg::CoordW;
  localparam int unsigned SW = c3wf_pkg::SizeW;
  localparam int unsigned PW = c3wf_pkg::PixW;
  localparam int unsigned AW = c3wf_pkg::AddrW;
  localparam int unsigned KW = c3wf_pkg::WinIdxW;

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;
  localparam logic [1:0] StHold  = 2'd3;

  localparam logic [SW-1:0] MaxW = SW'(c3wf_pkg::MaxWidth);
  localparam logic [SW-1:0] MaxH = SW'(c3wf_pkg::MaxHeight);
  localparam logic [KW-1:0] LastK = KW'(c3wf_pkg::WinSize - 1);

  logic [SW-1:0] width_q, height_q;
  logic [SW-1:0] eff_w, eff_h;
  logic [CW-1:0] last_x, last_y;

  logic [1:0]    state_q, state_d;
  logic [KW-1:0] k_q;
  logic [1:0]    col_q, row_q;
  logic          rd_vld_q;
  logic [KW-1:0] rd_k_q;

  logic [CW-1:0] cx_q, cy_q, xm_q, xp_q, ym_q, yp_q;
  logic [CW-1:0] cx_d, cy_d;
  logic [PW-1:0] win_q [c3wf_pkg::WinSize];

  logic          out_valid_q;
  c3wf_pkg::out_beat_t out_q;

  logic          in_acc;
  logic          wr_in_range;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [CW-1:0] sel_x, sel_y;
  logic [PW-1:0] mem [c3wf_pkg::StoreDepth];
  logic [PW-1:0] rd_data_q;
  logic          out_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxW;
      height_q <= MaxH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        c3wf_pkg::CfgWidth:  width_q  <= cfg_data_i;
        c3wf_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    eff_w = (width_q == '0) ? SW'(1) : ((width_q > MaxW) ? MaxW : width_q);
    eff_h = (height_q == '0) ? SW'(1) : ((height_q > MaxH) ? MaxH : height_q);
  end
  assign last_x = CW'(eff_w - SW'(1));
  assign last_y = CW'(eff_h - SW'(1));

  // Handshake and centre clamp
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign wr_in_range = ({1'b0, in_data_i.pos_x} < eff_w) && ({1'b0, in_data_i.pos_y} < eff_h);
  assign cx_d = ({1'b0, in_data_i.pos_x} >= eff_w) ? last_x : in_data_i.pos_x;
  assign cy_d = ({1'b0, in_data_i.pos_y} >= eff_h) ? last_y : in_data_i.pos_y;
  assign out_load = (state_q == StHold) && (!out_valid_q || out_ready_i);

  // Neighbor coordinates, clamped once per window
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      xm_q <= (cx_d == '0) ? '0 : cx_d - CW'(1);
      xp_q <= (cx_d == last_x) ? cx_d : cx_d + CW'(1);
      ym_q <= (cy_d == '0) ? '0 : cy_d - CW'(1);
      yp_q <= (cy_d == last_y) ? cy_d : cy_d + CW'(1);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc && in_data_i.op == c3wf_pkg::OpRead) state_d = StFetch;
      StFetch: if (k_q == LastK) state_d = StFlush;
      StFlush: state_d = StHold;
      StHold:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Fetch counters: window index plus row and column of the 3x3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      k_q      <= '0;
      col_q    <= '0;
      row_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_k_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == StFetch);
      rd_k_q   <= k_q;
      if (state_q == StFetch) begin
        k_q <= k_q + KW'(1);
        if (col_q == 2'd2) begin
          col_q <= '0;
          row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end else begin
        k_q   <= '0;
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

  // Store address: fetch position while reading, beat position otherwise
  always_comb begin
    case (col_q)
      2'd0:    sel_x = xm_q;
      2'd1:    sel_x = cx_q;
      default: sel_x = xp_q;
    endcase
    case (row_q)
      2'd0:    sel_y = ym_q;
      2'd1:    sel_y = cy_q;
      default: sel_y = yp_q;
    endcase
  end
  assign mem_we   = in_acc && (in_data_i.op == c3wf_pkg::OpWrite) && wr_in_range;
  assign mem_addr = (state_q == StFetch) ? {sel_y, sel_x}
                                         : {in_data_i.pos_y, in_data_i.pos_x};

  // Single-port image store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= in_data_i.pixel_in;
    end
    rd_data_q <= mem[mem_addr];
  end

  // Collect the nine pixels
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      win_q[rd_k_q] <= rd_data_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.centre_x <= cx_q;
      out_q.centre_y <= cy_q;
      out_q.nw       <= win_q[0];
      out_q.n        <= win_q[1];
      out_q.ne       <= win_q[2];
      out_q.w        <= win_q[3];
      out_q.c        <= win_q[4];
      out_q.e        <= win_q[5];
      out_q.sw       <= win_q[6];
      out_q.s        <= win_q[7];
      out_q.se       <= win_q[8];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
